FILE: hw/rtl/i2r_pkg.sv
`default_nettype none

package i2r_pkg;

    localparam int unsigned NumW = 12;
    localparam int unsigned DecW = 10;

    typedef enum logic [2:0] {
        SYM_I   = 3'd0,
        SYM_V   = 3'd1,
        SYM_X   = 3'd2,
        SYM_L   = 3'd3,
        SYM_C   = 3'd4,
        SYM_D   = 3'd5,
        SYM_M   = 3'd6,
        SYM_EOL = 3'd7
    } t_sym;

    // One greedy step: first symbol, optional second symbol, amount to remove.
    typedef struct packed {
        t_sym            sym1;
        logic            pair;
        t_sym            sym2;
        logic [DecW-1:0] dec;
    } t_step;

    typedef struct packed {
        logic load;
        logic step;
        logic eol;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

    function automatic t_step roman_step(input logic [NumW-1:0] value);
        t_step s;
        s.pair = 1'b0;
        s.sym2 = SYM_I;
        if (value >= NumW'(1000)) begin
            s.sym1 = SYM_M; s.dec = DecW'(1000);
        end else if (value >= NumW'(900)) begin
            s.sym1 = SYM_C; s.pair = 1'b1; s.sym2 = SYM_M; s.dec = DecW'(900);
        end else if (value >= NumW'(500)) begin
            s.sym1 = SYM_D; s.dec = DecW'(500);
        end else if (value >= NumW'(400)) begin
            s.sym1 = SYM_C; s.pair = 1'b1; s.sym2 = SYM_D; s.dec = DecW'(400);
        end else if (value >= NumW'(100)) begin
            s.sym1 = SYM_C; s.dec = DecW'(100);
        end else if (value >= NumW'(90)) begin
            s.sym1 = SYM_X; s.pair = 1'b1; s.sym2 = SYM_C; s.dec = DecW'(90);
        end else if (value >= NumW'(50)) begin
            s.sym1 = SYM_L; s.dec = DecW'(50);
        end else if (value >= NumW'(40)) begin
            s.sym1 = SYM_X; s.pair = 1'b1; s.sym2 = SYM_L; s.dec = DecW'(40);
        end else if (value >= NumW'(10)) begin
            s.sym1 = SYM_X; s.dec = DecW'(10);
        end else if (value >= NumW'(9)) begin
            s.sym1 = SYM_I; s.pair = 1'b1; s.sym2 = SYM_X; s.dec = DecW'(9);
        end else if (value >= NumW'(5)) begin
            s.sym1 = SYM_V; s.dec = DecW'(5);
        end else if (value >= NumW'(4)) begin
            s.sym1 = SYM_I; s.pair = 1'b1; s.sym2 = SYM_V; s.dec = DecW'(4);
        end else begin
            s.sym1 = SYM_I; s.dec = DecW'(1);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/integer_to_roman_numeral.sv
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+-----------------------------------
// input    | i_number[11:0]                 | taken when start && !busy
// result   | o_symbol[2:0], o_last          | o_strobe, one cycle, cannot stall
//
// Each item is loaded and then emits its results; the numeral is peeled off
// one symbol per cycle by a greedy compare-and-subtract on the remaining
// value.
// Results appear from a register, in the cycle after the step that makes them.
// Reset is synchronous and active low; it returns the controller to idle.
`default_nettype none

module integer_to_roman_numeral (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [11:0] i_number,
    output logic             o_strobe,
    output logic [2:0]       o_symbol,
    output logic             o_last
);

    i2r_pkg::t_cmd    cmd;
    i2r_pkg::t_status status;

    i2r_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    i2r_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_number (i_number),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not make the block busy");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |=> !o_strobe)
        else $error("result emitted after an idle cycle");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("result directly follows the end of an item");

    a_eol_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last == (o_symbol == i2r_pkg::SYM_EOL)))
        else $error("end-of-line code and last flag disagree");

endmodule

`default_nettype wire

FILE: hw/rtl/i2r_ctrl.sv
`default_nettype none

module i2r_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire i2r_pkg::t_status  i_status,
    output i2r_pkg::t_cmd          o_cmd,
    output logic                   o_busy
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_cmd.eol  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                // close the item once nothing is left to emit
                if (i_status.done) begin
                    o_cmd.eol = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: hw/rtl/i2r_dp.sv
`default_nettype none

module i2r_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [i2r_pkg::NumW-1:0]      i_number,
    input  wire i2r_pkg::t_cmd                 i_cmd,
    output i2r_pkg::t_status                   o_status,
    output logic                               o_strobe,
    output logic [2:0]                         o_symbol,
    output logic                               o_last
);

    logic [i2r_pkg::NumW-1:0] r_value, n_value;
    logic                     r_pend, n_pend;
    i2r_pkg::t_sym            r_pend_sym, n_pend_sym;
    logic                     r_stb, n_stb;
    i2r_pkg::t_sym            r_sym, n_sym;
    logic                     r_last, n_last;
    i2r_pkg::t_step           step;

    assign step = i2r_pkg::roman_step(r_value);

    always_comb begin
        n_value    = r_value;
        n_pend     = r_pend;
        n_pend_sym = r_pend_sym;
        n_stb      = i_cmd.step | i_cmd.eol;
        n_sym      = r_sym;
        n_last     = i_cmd.eol;
        if (i_cmd.load) begin
            n_value = i_number;
            n_pend  = 1'b0;
        end else if (i_cmd.eol) begin
            n_sym = i2r_pkg::SYM_EOL;
        end else if (i_cmd.step) begin
            if (r_pend) begin
                // second half of a subtractive pair
                n_sym  = r_pend_sym;
                n_pend = 1'b0;
            end else begin
                n_sym      = step.sym1;
                n_value    = r_value - i2r_pkg::NumW'(step.dec);
                n_pend     = step.pair;
                n_pend_sym = step.sym2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stb  <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_stb  <= n_stb;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_pend_sym <= n_pend_sym;
        r_sym      <= n_sym;
        r_last     <= n_last;
    end

    assign o_status.done = !r_pend && (r_value == '0);
    assign o_strobe      = r_stb;
    assign o_symbol      = r_sym;
    assign o_last        = r_last;

endmodule

`default_nettype wire

FILE: sim/tb_integer_to_roman_numeral.sv
`timescale 1ns / 100ps

module tb_integer_to_roman_numeral;

    localparam int unsigned RandomItems = 300;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 24;
    localparam int unsigned IdlePct     = 13;

    typedef struct {
        logic [i2r_pkg::NumW-1:0] number;
        logic                     hold;    // wait for all symbols of earlier items first
        logic                     no_gap;  // never idle before this item
    } t_number_req;

    typedef struct {
        i2r_pkg::t_sym sym;
        logic          last;
    } t_glyph;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [i2r_pkg::NumW-1:0] i_number;
    logic                     o_strobe;
    logic [2:0]               o_symbol;
    logic                     o_last;

    t_number_req pending_numbers[$];
    t_glyph      glyphs_due[$];
    int          n_offered;
    int          n_taken;
    int          n_errors;
    int          n_cycles;
    t_glyph      seen;
    t_number_req req;

    integer_to_roman_numeral DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_number (i_number),
        .o_strobe (o_strobe),
        .o_symbol (o_symbol),
        .o_last   (o_last)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic void push_glyph(i2r_pkg::t_sym s, logic last);
        t_glyph g;
        g.sym  = s;
        g.last = last;
        glyphs_due.push_back(g);
    endfunction

    function automatic void expand_digit(int unsigned d, i2r_pkg::t_sym one,
                                         i2r_pkg::t_sym five, i2r_pkg::t_sym ten);
        int unsigned rem;
        rem = d;
        if (d == 9) begin
            push_glyph(one, 1'b0);
            push_glyph(ten, 1'b0);
        end else if (d == 4) begin
            push_glyph(one, 1'b0);
            push_glyph(five, 1'b0);
        end else begin
            if (rem >= 5) begin
                push_glyph(five, 1'b0);
                rem = rem - 5;
            end
            for (int unsigned k = 0; k < rem; k++)
                push_glyph(one, 1'b0);
        end
    endfunction

    // Thousands as repeated M, then one decimal digit at a time.
    function automatic void expand_numeral(logic [i2r_pkg::NumW-1:0] number);
        int unsigned v;
        int unsigned rest;
        v    = 32'(number);
        rest = v % 1000;
        for (int unsigned k = 0; k < v / 1000; k++)
            push_glyph(i2r_pkg::SYM_M, 1'b0);
        expand_digit(rest / 100, i2r_pkg::SYM_C, i2r_pkg::SYM_D, i2r_pkg::SYM_M);
        expand_digit((rest / 10) % 10, i2r_pkg::SYM_X, i2r_pkg::SYM_L, i2r_pkg::SYM_C);
        expand_digit(rest % 10, i2r_pkg::SYM_I, i2r_pkg::SYM_V, i2r_pkg::SYM_X);
        push_glyph(i2r_pkg::SYM_EOL, 1'b1);
    endfunction

    function automatic void queue_number(logic [i2r_pkg::NumW-1:0] number, logic hold,
                                         logic no_gap);
        t_number_req r;
        r.number = number;
        r.hold   = hold;
        r.no_gap = no_gap;
        pending_numbers.push_back(r);
    endfunction

    // Random number whose decimal digits lean toward the four and nine patterns.
    function automatic logic [i2r_pkg::NumW-1:0] pick_patterned();
        int unsigned digits[4] = '{0, 4, 8, 9};
        int unsigned v;
        v = $urandom_range(0, 4) * 1000;
        v = v + ($urandom_range(0, 1) ? digits[$urandom_range(0, 3)]
                                      : $urandom_range(0, 9)) * 100;
        v = v + ($urandom_range(0, 1) ? digits[$urandom_range(0, 3)]
                                      : $urandom_range(0, 9)) * 10;
        v = v + ($urandom_range(0, 1) ? digits[$urandom_range(0, 3)]
                                      : $urandom_range(0, 9));
        if (v > 4095)
            v = 4000 + $urandom_range(0, 95);
        return i2r_pkg::NumW'(v);
    endfunction

    // Present the next number once the previous one has been taken, unless held or idling.
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || n_taken == n_offered)) begin
            if (pending_numbers.size() == 0) begin
                start    <= 1'b0;
                i_number <= i2r_pkg::NumW'($urandom);
            end else if (pending_numbers[0].hold && glyphs_due.size() != 0) begin
                start    <= 1'b0;
            end else if (!pending_numbers[0].no_gap && $urandom_range(0, 99) < IdlePct) begin
                start    <= 1'b0;
                i_number <= i2r_pkg::NumW'($urandom);
            end else begin
                req       = pending_numbers.pop_front();
                start    <= 1'b1;
                i_number <= req.number;
                n_offered = n_offered + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles = n_cycles + 1;
        if (n_cycles >= CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (glyphs_due.size() == 0) begin
                    $error("unexpected result: symbol %0d last %0b", o_symbol, o_last);
                    n_errors = n_errors + 1;
                end else begin
                    seen = glyphs_due.pop_front();
                    if (o_symbol !== seen.sym) begin
                        $error("symbol: expected %0d, got %0d", seen.sym, o_symbol);
                        n_errors = n_errors + 1;
                    end
                    if (o_last !== seen.last) begin
                        $error("last: expected %0b, got %0b", seen.last, o_last);
                        n_errors = n_errors + 1;
                    end
                end
            end
            if (start && !busy) begin
                expand_numeral(i_number);
                n_taken = n_taken + 1;
            end
        end
    end

    initial begin
        logic [i2r_pkg::NumW-1:0] directed[25];
        int unsigned sel;
        logic [i2r_pkg::NumW-1:0] pick;

        directed = '{
            12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd10, 12'd40,
            12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd500, 12'd900,
            12'd999, 12'd1000, 12'd1994, 12'd2048, 12'd3888, 12'd3999,
            12'd4000, 12'd2730, 12'd4095
        };

        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_number  = '0;
        n_offered = 0;
        n_taken   = 0;
        n_errors  = 0;
        n_cycles  = 0;

        foreach (directed[k])
            queue_number(directed[k], k == 12, 1'b0);
        for (int unsigned k = 0; k < RandomItems; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
                pick = i2r_pkg::NumW'($urandom);
            else if (sel < 70)
                pick = i2r_pkg::NumW'($urandom_range(0, 99));
            else
                pick = pick_patterned();
            queue_number(pick, k == 60 || k == 250, k >= 120 && k < 200);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || n_taken != n_offered)
            @(posedge i_clk);
        while (glyphs_due.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
